>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the time-of-day counter RTL.
// No dependencies; included by the source files of the modules that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> hw/rtl/tod_pkg.sv
// Package for the time-of-day counter: request codes, time constants,
// controller-to-datapath command and status types. No dependencies.
`default_nettype none

package tod_pkg;

    typedef enum logic [2:0] {
        REQ_UP,
        REQ_DOWN,
        REQ_SET_HOUR,
        REQ_SET_MIN,
        REQ_SET_SEC,
        REQ_ADD,
        REQ_LOAD_SECS,
        REQ_LOAD_HMS
    } t_req;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } t_div;

    typedef logic [3:0] t_shift;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [4:0]  MAX_HOUR      = 5'd23;
    localparam logic [5:0]  MAX_MINSEC    = 6'd59;

    // Top bit positions of the restoring reductions.
    localparam t_shift DAY_TOP_SHIFT  = 4'd14;
    localparam t_shift HOUR_TOP_SHIFT = 4'd4;
    localparam t_shift MIN_TOP_SHIFT  = 4'd5;

    typedef struct packed {
        logic   start;
        logic   step;
        t_div   div_sel;
        t_shift shift;
        logic   fold;
        logic   sec_load;
        logic   emit;
    } t_dp_cmd;

    typedef struct packed {
        logic long_op;
    } t_dp_sts;

    function automatic logic [16:0] day_total(input logic [4:0] h, input logic [5:0] m,
                                              input logic [5:0] s);
        day_total = 17'(h) * 17'(SECS_PER_HOUR) + 17'(m) * 17'(SECS_PER_MIN) + 17'(s);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/time_of_day_counter.sv
// Top level of the 24-hour hh:mm:ss time-of-day counter.
// Instantiates tod_ctrl and tod_datapath; uses tod_pkg.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_req_type i_value i_*_arg
//   result    out        o_valid / i_stall    o_cur_* o_day_seconds
//
// Step, set, load-hms and add of zero or less: go straight to S_EMIT, which registers the result.
// Add of a positive count and load-seconds: run on the shared compare-subtract unit
// (15 steps mod 86400, fold and wrap, 5 hour bits, 6 minute bits, seconds, emit).
// One request in flight; the next transfer is taken once the result is registered,
// even while that result is still stalled. Reset clears the time to 00:00:00.
`default_nettype none

module time_of_day_counter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_req_type,
    input  wire logic signed [31:0] i_value,
    input  wire logic signed [7:0]  i_hour_arg,
    input  wire logic signed [7:0]  i_minute_arg,
    input  wire logic signed [7:0]  i_second_arg,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [4:0]              o_cur_hour,
    output logic [5:0]              o_cur_minute,
    output logic [5:0]              o_cur_second,
    output logic [16:0]             o_day_seconds
);
    import tod_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tod_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tod_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_hour_arg    (i_hour_arg),
        .i_minute_arg  (i_minute_arg),
        .i_second_arg  (i_second_arg),
        .o_cur_hour    (o_cur_hour),
        .o_cur_minute  (o_cur_minute),
        .o_cur_second  (o_cur_second),
        .o_day_seconds (o_day_seconds)
    );

endmodule

`default_nettype wire

>>> hw/rtl/tod_datapath.sv
// Datapath of the time-of-day counter: clock registers, shared
// compare-subtract unit, output registers. Depends on tod_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tod_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tod_pkg::t_dp_cmd i_cmd,
    output tod_pkg::t_dp_sts      o_sts,
    input  wire logic [2:0]       i_req_type,
    input  wire logic signed [31:0] i_value,
    input  wire logic signed [7:0]  i_hour_arg,
    input  wire logic signed [7:0]  i_minute_arg,
    input  wire logic signed [7:0]  i_second_arg,
    output logic [4:0]            o_cur_hour,
    output logic [5:0]            o_cur_minute,
    output logic [5:0]            o_cur_second,
    output logic [16:0]           o_day_seconds
);
    import tod_pkg::*;

    t_req        req;
    logic [31:0] val_u;
    logic [31:0] divisor;
    logic [31:0] shifted;
    logic        fits;
    logic [16:0] cur_total;

    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [31:0] r_acc;
    logic [16:0] r_total;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_minute;
    logic [5:0]  r_o_second;
    logic [16:0] r_o_day_seconds;

    always_comb begin
        req   = t_req'(i_req_type);
        val_u = $unsigned(i_value);
        o_sts.long_op = (req == REQ_ADD && !i_value[31] && val_u != 32'd0) ||
                        (req == REQ_LOAD_SECS);
        case (i_cmd.div_sel)
            DIV_DAY:  divisor = 32'(SECS_PER_DAY);
            DIV_HOUR: divisor = 32'(SECS_PER_HOUR);
            DIV_MIN:  divisor = 32'(SECS_PER_MIN);
            default:  divisor = 32'(SECS_PER_DAY);
        endcase
        shifted   = divisor << i_cmd.shift;
        fits      = r_acc >= shifted;
        cur_total = day_total(r_hour, r_min, r_sec);
    end

    always_comb begin
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        if (i_cmd.start) begin
            case (req)
                REQ_UP: begin
                    if (r_sec == MAX_MINSEC) begin
                        n_sec = 6'd0;
                        if (r_min == MAX_MINSEC) begin
                            n_min  = 6'd0;
                            n_hour = (r_hour == MAX_HOUR) ? 5'd0 : r_hour + 5'd1;
                        end else begin
                            n_min = r_min + 6'd1;
                        end
                    end else begin
                        n_sec = r_sec + 6'd1;
                    end
                end
                REQ_DOWN: begin
                    if (r_sec == 6'd0) begin
                        n_sec = MAX_MINSEC;
                        if (r_min == 6'd0) begin
                            n_min  = MAX_MINSEC;
                            n_hour = (r_hour == 5'd0) ? MAX_HOUR : r_hour - 5'd1;
                        end else begin
                            n_min = r_min - 6'd1;
                        end
                    end else begin
                        n_sec = r_sec - 6'd1;
                    end
                end
                REQ_SET_HOUR: begin
                    if (val_u <= 32'(MAX_HOUR)) n_hour = val_u[4:0];
                end
                REQ_SET_MIN: begin
                    if (val_u <= 32'(MAX_MINSEC)) n_min = val_u[5:0];
                end
                REQ_SET_SEC: begin
                    if (val_u <= 32'(MAX_MINSEC)) n_sec = val_u[5:0];
                end
                REQ_LOAD_HMS: begin
                    if ($unsigned(i_hour_arg) <= 8'(MAX_HOUR) &&
                        $unsigned(i_minute_arg) <= 8'(MAX_MINSEC) &&
                        $unsigned(i_second_arg) <= 8'(MAX_MINSEC)) begin
                        n_hour = i_hour_arg[4:0];
                        n_min  = i_minute_arg[5:0];
                        n_sec  = i_second_arg[5:0];
                    end else begin
                        n_hour = 5'd0;
                        n_min  = 6'd0;
                        n_sec  = 6'd0;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.step && i_cmd.div_sel == DIV_HOUR) begin
            n_hour = {r_hour[3:0], fits};
        end else if (i_cmd.step && i_cmd.div_sel == DIV_MIN) begin
            n_min = {r_min[4:0], fits};
        end else if (i_cmd.sec_load) begin
            n_sec = r_acc[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour <= 5'd0;
            r_min  <= 6'd0;
            r_sec  <= 6'd0;
        end else begin
            r_hour <= n_hour;
            r_min  <= n_min;
            r_sec  <= n_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc   <= (req == REQ_LOAD_SECS && i_value[31]) ? 32'd0 : val_u;
            r_total <= (req == REQ_ADD) ? cur_total : 17'd0;
        end else if (i_cmd.step && fits) begin
            r_acc <= r_acc - shifted;
        end else if (i_cmd.fold) begin
            r_acc <= r_acc + 32'(r_total);
        end
        if (i_cmd.emit) begin
            r_o_hour        <= r_hour;
            r_o_minute      <= r_min;
            r_o_second      <= r_sec;
            r_o_day_seconds <= cur_total;
        end
    end

    assign o_cur_hour    = r_o_hour;
    assign o_cur_minute  = r_o_minute;
    assign o_cur_second  = r_o_second;
    assign o_day_seconds = r_o_day_seconds;

    `ASSERT_IMPLY(a_split_below_day, i_clk, i_rst_n, i_cmd.step && i_cmd.div_sel == DIV_HOUR, r_acc < 32'(SECS_PER_DAY))
    `ASSERT_NEXT(a_emit_in_range, i_clk, i_rst_n, i_cmd.emit, r_o_day_seconds < SECS_PER_DAY && r_o_hour <= MAX_HOUR)

endmodule

`default_nettype wire

>>> hw/rtl/tod_ctrl.sv
// Controller of the time-of-day counter: request sequencing, reduction
// bit counter and output valid. Depends on tod_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tod_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  wire tod_pkg::t_dp_sts i_sts,
    output tod_pkg::t_dp_cmd      o_cmd
);
    import tod_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAY,
        S_FOLD,
        S_WRAP,
        S_HOUR,
        S_MIN,
        S_SEC,
        S_EMIT
    } t_state;

    t_state r_state;
    t_shift r_shift;
    logic   r_out_valid;
    logic   emit_ok;

    always_comb begin
        emit_ok = !r_out_valid || !i_stall;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_DAY;
        o_cmd.shift   = r_shift;
        case (r_state)
            S_IDLE: o_cmd.start = i_valid;
            S_DAY:  o_cmd.step = 1'b1;
            S_FOLD: o_cmd.fold = 1'b1;
            S_WRAP: begin
                o_cmd.step  = 1'b1;
                o_cmd.shift = '0;
            end
            S_HOUR: begin
                o_cmd.step    = 1'b1;
                o_cmd.div_sel = DIV_HOUR;
            end
            S_MIN: begin
                o_cmd.step    = 1'b1;
                o_cmd.div_sel = DIV_MIN;
            end
            S_SEC:  o_cmd.sec_load = 1'b1;
            S_EMIT: o_cmd.emit = emit_ok;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_out_valid && i_stall) || (r_state == S_EMIT && emit_ok);
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_sts.long_op) begin
                            r_state <= S_DAY;
                            r_shift <= DAY_TOP_SHIFT;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DAY: begin
                    if (r_shift == '0) r_state <= S_FOLD;
                    else r_shift <= r_shift - 4'd1;
                end
                S_FOLD: r_state <= S_WRAP;
                S_WRAP: begin
                    r_state <= S_HOUR;
                    r_shift <= HOUR_TOP_SHIFT;
                end
                S_HOUR: begin
                    if (r_shift == '0) begin
                        r_state <= S_MIN;
                        r_shift <= MIN_TOP_SHIFT;
                    end else begin
                        r_shift <= r_shift - 4'd1;
                    end
                end
                S_MIN: begin
                    if (r_shift == '0) r_state <= S_SEC;
                    else r_shift <= r_shift - 4'd1;
                end
                S_SEC: r_state <= S_EMIT;
                S_EMIT: begin
                    if (emit_ok) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_valid && r_state == S_IDLE, r_state != S_IDLE)
    `ASSERT_NEXT(a_emit_sets_valid, i_clk, i_rst_n, o_cmd.emit, r_out_valid && r_state == S_IDLE)

endmodule

`default_nettype wire
